// File: src/tcprcw_pkg.sv
// ----------------------------------------------------------------------------
// TCP Reno congestion window - shared definitions
// Request and phase codes, register indexes, reset values, field widths and
// the command and status bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package tcprcw_pkg;

    // default congestion window width
    localparam int WINDOW_WIDTH_DEF = 32;

    // field widths
    localparam int SEG_W      = 16;
    localparam int INIT_SEG_W = 5;
    localparam int THR_W      = 32;
    localparam int DUPT_W     = 8;
    localparam int REQ_W      = 2;
    localparam int SEQ_W      = 32;
    localparam int PEER_W     = 16;
    localparam int LEN_W      = 16;
    localparam int PHASE_W    = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;
    localparam int IN_DATA_W  = 136;
    localparam int OUT_DATA_W = 104;

    // request kinds
    localparam logic [REQ_W-1:0] REQ_ACK     = 2'd0;
    localparam logic [REQ_W-1:0] REQ_TIMEOUT = 2'd1;
    localparam logic [REQ_W-1:0] REQ_QUERY   = 2'd2;
    localparam logic [REQ_W-1:0] REQ_RESTART = 2'd3;

    // congestion phases
    localparam logic [PHASE_W-1:0] PH_SLOW    = 2'd0;
    localparam logic [PHASE_W-1:0] PH_AVOID   = 2'd1;
    localparam logic [PHASE_W-1:0] PH_RECOVER = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SEG_SIZE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INIT_SEGS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_INIT_THR  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DUP_THR   = 2'd3;

    // configuration reset values
    localparam logic [SEG_W-1:0]      RST_SEG_SIZE  = 16'd1460;
    localparam logic [INIT_SEG_W-1:0] RST_INIT_SEGS = 5'd1;
    localparam logic [THR_W-1:0]      RST_INIT_THR  = 32'd65535;
    localparam logic [DUPT_W-1:0]     RST_DUP_THR   = 8'd3;

    // duplicate counter ceiling
    localparam logic [DUPT_W-1:0] DUP_MAX = 8'd255;

    // controller to datapath commands
    typedef struct packed {
        logic load_in;
        logic mul_load;
        logic div_start;
        logic commit;
    } t_dp_cmd;

    // datapath to controller status
    typedef struct packed {
        logic need_div;
        logic div_done;
    } t_dp_sts;

endpackage

`default_nettype wire

// File: src/tcprcw_div.sv
// ----------------------------------------------------------------------------
// TCP Reno congestion window - serial divider
// Restoring divider: 32-bit dividend by a DW-bit divisor, one quotient bit
// per cycle, done pulse in the cycle after the last step.
// ----------------------------------------------------------------------------
`default_nettype none

module tcprcw_div
    import tcprcw_pkg::*;
#(
    parameter int DW = WINDOW_WIDTH_DEF
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_start,
    input  wire logic [31:0]   i_dividend,
    input  wire logic [DW-1:0] i_divisor,
    output logic               o_done,
    output logic [31:0]        o_quotient
);

    logic [DW-1:0] r_rem;
    logic [31:0]   r_quo;
    logic [5:0]    r_cnt;
    logic          r_busy;
    logic          r_done;

    logic [DW:0]   w_shift;
    logic [DW+1:0] w_diff;

    // trial subtract of the shifted remainder
    assign w_shift = {r_rem, r_quo[31]};
    assign w_diff  = {1'b0, w_shift} - {2'b00, i_divisor};

    // control: step count and done pulse
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= 6'd32;
            end else if (r_busy) begin
                r_cnt <= r_cnt - 6'd1;
                if (r_cnt == 6'd1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // datapath: shift in one quotient bit per step
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
        end else if (r_busy) begin
            if (!w_diff[DW+1]) begin
                r_rem <= w_diff[DW-1:0];
                r_quo <= {r_quo[30:0], 1'b1};
            end else begin
                r_rem <= w_shift[DW-1:0];
                r_quo <= {r_quo[30:0], 1'b0};
            end
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

`default_nettype wire

// File: src/tcprcw_dpath.sv
// ----------------------------------------------------------------------------
// TCP Reno congestion window - datapath
// Configuration registers, window state, request capture, the avoidance
// increment (square then divide) and the result word register.
// ----------------------------------------------------------------------------
`default_nettype none

module tcprcw_dpath
    import tcprcw_pkg::*;
#(
    parameter int WINDOW_WIDTH = WINDOW_WIDTH_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic [IN_DATA_W-1:0]  i_in_data,
    input  wire logic [REQ_W-1:0]      i_in_req,
    input  wire t_dp_cmd               i_cmd,
    output t_dp_sts                    o_sts,
    output logic [OUT_DATA_W-1:0]      o_out_data
);

    localparam int W  = WINDOW_WIDTH;
    localparam int SW = ((W > 33) ? W : 33) + 1;
    localparam logic [SW-1:0] CWND_MAX_X = {{(SW-W){1'b0}}, {W{1'b1}}};
    localparam logic [SW-1:0] U32_MAX_X  = {{(SW-32){1'b0}}, {32{1'b1}}};
    localparam int RST_CWND = int'(RST_SEG_SIZE) * int'(RST_INIT_SEGS);

    // configuration
    logic [SEG_W-1:0]      r_seg;
    logic [INIT_SEG_W-1:0] r_init_segs;
    logic [THR_W-1:0]      r_init_thr;
    logic [DUPT_W-1:0]     r_dup_thr;

    // window state
    logic [W-1:0]         r_cwnd,     n_cwnd;
    logic [THR_W-1:0]     r_ssthresh, n_ssthresh;
    logic [PHASE_W-1:0]   r_phase,    n_phase;
    logic [SEQ_W-1:0]     r_prev_ack, n_prev_ack;
    logic [DUPT_W-1:0]    r_dup_cnt,  n_dup_cnt;
    logic [PEER_W-1:0]    r_eff,      n_eff;

    // captured request
    logic [REQ_W-1:0]  r_req;
    logic [SEQ_W-1:0]  r_ack;
    logic              r_dup;
    logic [PEER_W-1:0] r_peer;
    logic [SEQ_W-1:0]  r_nseq;
    logic [SEQ_W-1:0]  r_oldest;
    logic [LEN_W-1:0]  r_slen;

    // avoidance increment
    logic [31:0]  r_seg_sq;
    logic [31:0]  w_quo;
    logic         w_div_done;
    logic [W-1:0] w_divisor;

    // result word
    logic [OUT_DATA_W-1:0] r_out;

    // shared arithmetic
    logic [SW-1:0]     w_cwnd_x, w_seg_x;
    logic [SW-1:0]     w_half_x, w_half_max;
    logic [THR_W-1:0]  w_half_thr;
    logic [17:0]       w_seg3;
    logic [SW-1:0]     w_fr_sum, w_rec_sum, w_ss_sum, w_av_sum, w_thr_x;
    logic [20:0]       w_init_prod;
    logic [SW-1:0]     w_init_x;
    logic [32:0]       w_need;
    logic [SEQ_W-1:0]  w_flight;
    logic [DUPT_W-1:0] w_dup_inc;
    logic              w_new_ack;
    logic              w_send_ok, w_retx;
    logic [31:0]       w_win_out;

    // write configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seg       <= RST_SEG_SIZE;
            r_init_segs <= RST_INIT_SEGS;
            r_init_thr  <= RST_INIT_THR;
            r_dup_thr   <= RST_DUP_THR;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_SEG_SIZE:  r_seg       <= i_cfg_data[SEG_W-1:0];
                CFG_INIT_SEGS: r_init_segs <= i_cfg_data[INIT_SEG_W-1:0];
                CFG_INIT_THR:  r_init_thr  <= i_cfg_data[THR_W-1:0];
                CFG_DUP_THR:   r_dup_thr   <= i_cfg_data[DUPT_W-1:0];
                default: ;
            endcase
        end
    end

    // capture the request word
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_req    <= i_in_req;
            r_ack    <= i_in_data[31:0];
            r_dup    <= i_in_data[32];
            r_peer   <= i_in_data[48:33];
            r_nseq   <= i_in_data[80:49];
            r_oldest <= i_in_data[112:81];
            r_slen   <= i_in_data[128:113];
        end
    end

    // square the segment size ahead of the divide
    always_ff @(posedge i_clk) begin
        if (i_cmd.mul_load) begin
            r_seg_sq <= 32'(r_seg) * 32'(r_seg);
        end
    end

    // zero window divides as one
    assign w_divisor = (r_cwnd == '0) ? W'(1) : r_cwnd;

    tcprcw_div #(
        .DW (W)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (r_seg_sq),
        .i_divisor  (w_divisor),
        .o_done     (w_div_done),
        .o_quotient (w_quo)
    );

    // candidate values, widened so that no sum wraps
    assign w_cwnd_x   = SW'(r_cwnd);
    assign w_seg_x    = SW'(r_seg);
    assign w_half_x   = SW'(r_cwnd >> 1);
    assign w_half_max = (w_half_x < w_seg_x) ? w_seg_x : w_half_x;
    assign w_half_thr = (w_half_max > U32_MAX_X) ? {THR_W{1'b1}} : w_half_max[THR_W-1:0];
    assign w_seg3     = 18'(r_seg) + {1'b0, r_seg, 1'b0};
    assign w_fr_sum   = SW'(w_half_thr) + SW'(w_seg3);
    assign w_rec_sum  = w_cwnd_x + w_seg_x;
    assign w_ss_sum   = (w_rec_sum > CWND_MAX_X) ? CWND_MAX_X : w_rec_sum;
    assign w_av_sum   = w_cwnd_x + SW'(w_quo);
    assign w_thr_x    = SW'(r_ssthresh);
    assign w_init_prod = 21'(r_init_segs) * 21'(r_seg);
    assign w_init_x   = SW'(w_init_prod);
    assign w_flight   = r_nseq - r_oldest;
    assign w_need     = 33'(w_flight) + 33'(r_slen);
    assign w_dup_inc  = r_dup_cnt + 8'd1;
    assign w_new_ack  = (r_ack != r_prev_ack);

    // next state for the captured request
    always_comb begin
        n_cwnd     = r_cwnd;
        n_ssthresh = r_ssthresh;
        n_phase    = r_phase;
        n_prev_ack = r_prev_ack;
        n_dup_cnt  = r_dup_cnt;
        n_eff      = r_eff;
        w_send_ok  = 1'b0;
        w_retx     = 1'b0;
        unique case (r_req)
            REQ_ACK: begin
                if (!w_new_ack) begin
                    // duplicate: count, maybe enter fast recovery
                    if (r_dup) begin
                        if (r_dup_cnt != DUP_MAX) begin
                            n_dup_cnt = w_dup_inc;
                        end
                        if (r_dup_cnt != DUP_MAX && w_dup_inc == r_dup_thr) begin
                            n_ssthresh = w_half_thr;
                            n_cwnd     = (w_fr_sum > CWND_MAX_X) ? {W{1'b1}} : w_fr_sum[W-1:0];
                            n_phase    = PH_RECOVER;
                            w_retx     = 1'b1;
                        end else if (r_phase == PH_RECOVER) begin
                            n_cwnd = w_ss_sum[W-1:0];
                        end
                    end
                end else begin
                    // new ACK: leave recovery at the threshold, else grow the window by phase
                    n_prev_ack = r_ack;
                    n_dup_cnt  = '0;
                    case (r_phase)
                        PH_RECOVER: begin
                            n_cwnd  = (w_thr_x > CWND_MAX_X) ? {W{1'b1}} : w_thr_x[W-1:0];
                            n_phase = PH_AVOID;
                        end
                        PH_SLOW: begin
                            n_cwnd = w_ss_sum[W-1:0];
                            if (w_ss_sum >= w_thr_x) begin
                                n_phase = PH_AVOID;
                            end
                        end
                        PH_AVOID: begin
                            n_cwnd = (w_av_sum > CWND_MAX_X) ? {W{1'b1}} : w_av_sum[W-1:0];
                        end
                        default: ;
                    endcase
                    n_eff = (SW'(n_cwnd) < SW'(r_peer)) ? n_cwnd[PEER_W-1:0] : r_peer;
                end
            end
            REQ_TIMEOUT: begin
                n_ssthresh = w_half_thr;
                n_cwnd     = W'(r_seg);
                n_dup_cnt  = '0;
                n_phase    = PH_SLOW;
            end
            REQ_QUERY: begin
                w_send_ok = (SW'(w_need) <= w_cwnd_x);
            end
            REQ_RESTART: begin
                n_cwnd     = (w_init_x > CWND_MAX_X) ? {W{1'b1}} : w_init_x[W-1:0];
                n_ssthresh = r_init_thr;
                n_phase    = PH_SLOW;
                n_prev_ack = '0;
                n_dup_cnt  = '0;
                n_eff      = '0;
            end
            default: ;
        endcase
    end

    // clamp the reported window to 32 bits
    assign w_win_out = (SW'(n_cwnd) > U32_MAX_X) ? 32'hFFFF_FFFF : 32'(n_cwnd);

    // commit the new state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cwnd     <= W'(RST_CWND);
            r_ssthresh <= RST_INIT_THR;
            r_phase    <= PH_SLOW;
            r_prev_ack <= '0;
            r_dup_cnt  <= '0;
            r_eff      <= '0;
        end else if (i_cmd.commit) begin
            r_cwnd     <= n_cwnd;
            r_ssthresh <= n_ssthresh;
            r_phase    <= n_phase;
            r_prev_ack <= n_prev_ack;
            r_dup_cnt  <= n_dup_cnt;
            r_eff      <= n_eff;
        end
    end

    // load the result word
    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_out <= {4'b0000, w_retx, w_send_ok, 16'h0000, n_eff, n_phase,
                      n_ssthresh, w_win_out};
        end
    end

    assign o_sts.need_div = (r_req == REQ_ACK) && w_new_ack && (r_phase == PH_AVOID);
    assign o_sts.div_done = w_div_done;
    assign o_out_data     = r_out;

endmodule

`default_nettype wire

// File: src/tcprcw_ctrl.sv
// ----------------------------------------------------------------------------
// TCP Reno congestion window - controller
// Sequences one request: capture, optional square and divide, then commit
// into the result register once it is free.
// ----------------------------------------------------------------------------
`default_nettype none

module tcprcw_ctrl
    import tcprcw_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_in_valid,
    output logic      o_in_ready,
    output logic      o_out_valid,
    input  wire logic i_out_ready,
    input  wire t_dp_sts i_sts,
    output t_dp_cmd   o_cmd
);

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_CHECK  = 6'b000010,
        S_MUL    = 6'b000100,
        S_DSTART = 6'b001000,
        S_DWAIT  = 6'b010000,
        S_FIN    = 6'b100000
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   w_accept, w_slot_free;

    assign w_accept    = i_in_valid && (r_state == S_IDLE);
    assign w_slot_free = !r_out_valid || i_out_ready;

    // advance through the request
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                o_cmd.load_in = w_accept;
                if (w_accept) begin
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                n_state = i_sts.need_div ? S_MUL : S_FIN;
            end
            S_MUL: begin
                o_cmd.mul_load = 1'b1;
                n_state        = S_DSTART;
            end
            S_DSTART: begin
                o_cmd.div_start = 1'b1;
                n_state         = S_DWAIT;
            end
            S_DWAIT: begin
                if (i_sts.div_done) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                if (w_slot_free) begin
                    o_cmd.commit = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // hold the result valid until taken
    always_comb begin
        n_out_valid = r_out_valid && !i_out_ready;
        if (o_cmd.commit) begin
            n_out_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

`default_nettype wire

// File: src/tcp_reno_congestion_window.sv
// ----------------------------------------------------------------------------
// TCP Reno congestion window engine
// Request words come in on the slave stream: tuser carries the request kind
// (ACK, timeout, send query, restart), tdata the ACK and query fields. Each
// request yields one result word on the master stream with the window,
// threshold, phase, usable window, send permission and fast retransmit flag.
// Configuration registers (segment size, initial segments, initial threshold,
// duplicate threshold) have a plain write port that the user must use only while idle; the
// block itself does not enforce this. A request passes the capture, check and
// commit states; a new ACK in congestion avoidance also passes the square and
// divide states, where the 32-step serial divider forms segment size squared
// over the window. One request is in work at a time, so the next request is
// taken only once the current one has committed.
// The result sits in an output register: the next request is taken while a
// result waits, but a finished request whose result register is still full
// holds until the receiver takes the waiting word.
// Reset loads the default configuration and the slow start state; a restart
// request reloads the state from the current configuration.
// ----------------------------------------------------------------------------
`default_nettype none

module tcp_reno_congestion_window
    import tcprcw_pkg::*;
#(
    parameter int WINDOW_WIDTH = WINDOW_WIDTH_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    // configuration write port
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    // request stream
    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    // ack_number[31:0], dup_flag[32], peer_window[48:33], next_sequence[80:49],
    // oldest_acked[112:81], send_length[128:113], zero fill
    input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,
    // req_type[1:0]
    input  wire logic [REQ_W-1:0]      s_axis_tuser,
    // result stream
    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    // window_bytes[31:0], threshold_bytes[63:32], phase[65:64],
    // usable_window[81:66], zero[97:82], send_ok[98], retransmit_now[99], zero fill
    output logic [OUT_DATA_W-1:0]      m_axis_tdata
);

    t_dp_cmd w_cmd;
    t_dp_sts w_sts;

    tcprcw_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd)
    );

    tcprcw_dpath #(
        .WINDOW_WIDTH (WINDOW_WIDTH)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_data   (s_axis_tdata),
        .i_in_req    (s_axis_tuser),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .o_out_data  (m_axis_tdata)
    );

    // commit only into a free result register
    a_commit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.commit |-> (!m_axis_tvalid || m_axis_tready))
        else $error("result committed over a waiting word");

    // a commit always presents a result next cycle
    a_commit_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.commit |=> m_axis_tvalid)
        else $error("committed result not presented");

    // one request at a time
    a_single_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("request taken while another is in work");

    // divide never starts while committing
    a_div_commit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_cmd.div_start && w_cmd.commit))
        else $error("divider started during commit");

endmodule

`default_nettype wire
